### rtl/apdu_command_parser_defines.svh
// Assertion macros shared by the checker files of the command APDU parser.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef APDU_COMMAND_PARSER_DEFINES_SVH
`define APDU_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/acp_pkg.sv
// Types and constants of the command APDU parser.
// Used by every module of the block and by its checker; depends on nothing.
package acp_pkg;

  localparam int unsigned QDEPTH = 2;

  localparam logic [16:0] CNT_MAX     = 17'h1FFFF;
  localparam logic [16:0] LONG_IDX    = 17'h0FFFF;  // index at which length exceeds 65535
  localparam logic [16:0] IDX_B4      = 17'd4;
  localparam logic [16:0] IDX_B5      = 17'd5;
  localparam logic [16:0] IDX_B6      = 17'd6;
  localparam logic [15:0] HDR_LEN     = 16'd4;
  localparam logic [15:0] SHORT_LE_LEN = 16'd5;
  localparam logic [15:0] EXT_LE_LEN  = 16'd7;
  localparam logic [7:0]  EXT_MARK    = 8'h00;
  localparam logic [2:0]  NO_OFF      = 3'd0;
  localparam logic [2:0]  SHORT_OFF   = 3'd5;
  localparam logic [2:0]  EXT_OFF     = 3'd7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } acp_in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [15:0] lc;
    logic [15:0] le;
    logic        has_le;
    logic [2:0]  data_offset;
  } acp_out_t;

  // One finished APDU as captured by the front part, current byte merged in.
  typedef struct packed {
    logic            too_long;
    logic [15:0]     len;
    logic [3:0][7:0] hdr;
    logic [7:0]      b4;
    logic [7:0]      b5;
    logic [7:0]      b6;
    logic [7:0]      t1;
    logic [7:0]      t0;
  } acp_rec_t;

endpackage

### rtl/acp_front.sv
// Front part of the command APDU parser: counts and captures bytes.
// Emits one acp_pkg::acp_rec_t record per final byte; depends on acp_pkg.
module acp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  acp_pkg::acp_in_t  item,
  output logic              rec_push,
  output acp_pkg::acp_rec_t rec
);

  logic [16:0]     byte_count_r;
  logic [3:0][7:0] hdr_r;
  logic [7:0]      b4_r;
  logic [7:0]      b5_r;
  logic [7:0]      b6_r;
  logic [7:0]      t0_r;

  logic [3:0][7:0] hdr_nxt;
  logic [7:0]      b4_nxt;
  logic [7:0]      b5_nxt;
  logic [7:0]      b6_nxt;
  logic [16:0]     byte_count_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hdr_nxt[i] = (byte_count_r == 17'(i)) ? item.in_byte : hdr_r[i];
    end
    b4_nxt = (byte_count_r == acp_pkg::IDX_B4) ? item.in_byte : b4_r;
    b5_nxt = (byte_count_r == acp_pkg::IDX_B5) ? item.in_byte : b5_r;
    b6_nxt = (byte_count_r == acp_pkg::IDX_B6) ? item.in_byte : b6_r;
    byte_count_nxt = (byte_count_r == acp_pkg::CNT_MAX) ? byte_count_r
                                                         : byte_count_r + 17'd1;
  end

  always_comb begin
    rec_push     = accept && item.last_byte;
    rec.too_long = (byte_count_r >= acp_pkg::LONG_IDX);
    rec.len      = byte_count_r[15:0] + 16'd1;
    rec.hdr      = hdr_nxt;
    rec.b4       = b4_nxt;
    rec.b5       = b5_nxt;
    rec.b6       = b6_nxt;
    rec.t1       = t0_r;
    rec.t0       = item.in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      hdr_r        <= '0;
      b4_r         <= '0;
      b5_r         <= '0;
      b6_r         <= '0;
      t0_r         <= '0;
    end else if (accept) begin
      if (item.last_byte) begin
        byte_count_r <= '0;
        hdr_r        <= '0;
        b4_r         <= '0;
        b5_r         <= '0;
        b6_r         <= '0;
        t0_r         <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        hdr_r        <= hdr_nxt;
        b4_r         <= b4_nxt;
        b5_r         <= b5_nxt;
        b6_r         <= b6_nxt;
        t0_r         <= item.in_byte;
      end
    end
  end

endmodule

### rtl/acp_cmd_queue.sv
// Two-entry queue of captured APDU records between front and back parts.
// Depends on acp_pkg.
module acp_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  acp_pkg::acp_rec_t push_rec,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output acp_pkg::acp_rec_t head
);

  acp_pkg::acp_rec_t mem_r [acp_pkg::QDEPTH];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  logic do_push;
  logic do_pop;

  assign full    = (count_r == 2'(acp_pkg::QDEPTH));
  assign empty   = (count_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

endmodule

### rtl/acp_back.sv
// Back part of the command APDU parser: classifies a captured record by the
// ISO 7816-4 rules and holds results in a two-entry output queue. Depends on acp_pkg.
module acp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_avail,
  input  acp_pkg::acp_rec_t rec,
  output logic              rec_take,
  input  logic              out_pop,
  output logic              out_empty,
  output acp_pkg::acp_out_t out_item
);

  acp_pkg::acp_out_t res;
  logic [15:0]       n;
  logic [15:0]       ext;
  logic [16:0]       ext_end;
  logic [16:0]       ext_end2;
  logic [15:0]       short_end;
  logic [15:0]       short_end1;

  acp_pkg::acp_out_t mem_r [acp_pkg::QDEPTH];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              oq_full;
  logic              do_pop;

  always_comb begin
    n          = rec.len;
    ext        = {rec.b5, rec.b6};
    ext_end    = {1'b0, ext} + 17'd7;
    ext_end2   = {1'b0, ext} + 17'd9;
    short_end  = {8'd0, rec.b4} + 16'd5;
    short_end1 = {8'd0, rec.b4} + 16'd6;

    res = '0;
    // An overlong APDU still reports its header bytes.
    if (rec.too_long || n >= acp_pkg::HDR_LEN) begin
      res.cla = rec.hdr[0];
      res.ins = rec.hdr[1];
      res.p1  = rec.hdr[2];
      res.p2  = rec.hdr[3];
    end
    if (!rec.too_long && n >= acp_pkg::HDR_LEN) begin
      if (n == acp_pkg::HDR_LEN) begin
        res.ok = 1'b1;
      end else if (rec.b4 == acp_pkg::EXT_MARK && n >= acp_pkg::EXT_LE_LEN) begin
        // Extended length: a zero marker byte followed by two length bytes.
        if (n == acp_pkg::EXT_LE_LEN) begin
          res.ok     = 1'b1;
          res.le     = ext;
          res.has_le = 1'b1;
        end else if ({1'b0, n} == ext_end) begin
          res.ok          = 1'b1;
          res.lc          = ext;
          res.data_offset = acp_pkg::EXT_OFF;
        end else if ({1'b0, n} == ext_end2) begin
          res.ok          = 1'b1;
          res.lc          = ext;
          res.data_offset = acp_pkg::EXT_OFF;
          res.has_le      = 1'b1;
          res.le          = {rec.t1, rec.t0};
        end
      end else if (n == acp_pkg::SHORT_LE_LEN) begin
        res.ok     = 1'b1;
        res.le     = {8'd0, rec.b4};
        res.has_le = 1'b1;
      end else if (rec.b4 != acp_pkg::EXT_MARK) begin
        if (n == short_end) begin
          res.ok          = 1'b1;
          res.lc          = {8'd0, rec.b4};
          res.data_offset = acp_pkg::SHORT_OFF;
        end else if (n == short_end1) begin
          res.ok          = 1'b1;
          res.lc          = {8'd0, rec.b4};
          res.data_offset = acp_pkg::SHORT_OFF;
          res.le          = {8'd0, rec.t0};
          res.has_le      = 1'b1;
        end
      end
    end
  end

  assign oq_full   = (count_r == 2'(acp_pkg::QDEPTH));
  assign rec_take  = rec_avail && !oq_full;
  assign out_empty = (count_r == 2'd0);
  assign out_item  = mem_r[rd_ptr_r];
  assign do_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (rec_take) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (rec_take) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)   rd_ptr_r <= !rd_ptr_r;
      if (rec_take && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !rec_take) count_r <= count_r - 2'd1;
    end
  end

endmodule

### rtl/apdu_command_parser.sv
// Command APDU parser: takes one byte per cycle, the last byte of each APDU
// flagged, and delivers one classified result per APDU: header only, short or
// extended Le only, short or extended data, or data followed by Le.
// Depends on acp_pkg, acp_front, acp_cmd_queue and acp_back.
//
// A byte is taken every cycle while in_full is low. Only the final byte of an
// APDU produces a record; records pass through a two-entry queue to the
// decoder, whose results wait in a two-entry output queue. A record is
// registered in the command queue and its result in the output queue, where
// it waits on out_item to be popped. in_full rises only when both queues hold
// records the consumer has not popped, so with pop held high the sustained
// rate is one byte per cycle.
module apdu_command_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  acp_pkg::acp_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output acp_pkg::acp_out_t out_item
);

  logic              accept;
  logic              rec_push;
  acp_pkg::acp_rec_t rec;
  logic              cq_full;
  logic              cq_empty;
  acp_pkg::acp_rec_t cq_head;
  logic              rec_take;

  assign in_full = cq_full;
  assign accept  = in_push && !cq_full;

  acp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .rec_push (rec_push),
    .rec      (rec)
  );

  acp_cmd_queue u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (rec_take),
    .full     (cq_full),
    .empty    (cq_empty),
    .head     (cq_head)
  );

  acp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_avail (!cq_empty),
    .rec       (cq_head),
    .rec_take  (rec_take),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

### rtl/acp_checker.sv
// Port-level checker of the command APDU parser, bound to the top level.
// Depends on acp_pkg and apdu_command_parser_defines.svh.
`include "apdu_command_parser_defines.svh"

module acp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input acp_pkg::acp_in_t  in_item,
  input logic              out_empty,
  input logic              out_pop,
  input acp_pkg::acp_out_t out_item
);

  // Results owed: final bytes taken minus results popped.
  logic [2:0] pending_r;
  logic       fin_acc;
  logic       res_acc;
  logic       no_lengths;
  logic       offset_legal;

  assign fin_acc = in_push && !in_full && in_item.last_byte;
  assign res_acc = out_pop && !out_empty;

  assign no_lengths = out_item.lc == 16'd0 && out_item.le == 16'd0 && !out_item.has_le &&
                      out_item.data_offset == acp_pkg::NO_OFF;
  assign offset_legal = out_item.data_offset == acp_pkg::NO_OFF ||
                        out_item.data_offset == acp_pkg::SHORT_OFF ||
                        out_item.data_offset == acp_pkg::EXT_OFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (fin_acc && !res_acc) begin
      pending_r <= pending_r + 3'd1;
    end else if (res_acc && !fin_acc) begin
      pending_r <= pending_r - 3'd1;
    end
  end

  `ACP_ASSERT_IMP(a_no_invented, !out_empty, pending_r != 3'd0, "result without a final byte")
  `ACP_ASSERT_IMP(a_bounded, 1'b1, pending_r <= 3'd4, "more results owed than storage holds")
  `ACP_ASSERT_IMP(a_invalid_zero, !out_empty && !out_item.ok, no_lengths, "invalid result has lengths")
  `ACP_ASSERT_IMP(a_offset_code, !out_empty, offset_legal, "bad data offset")
  `ACP_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_item), "held result changed")

endmodule

bind apdu_command_parser acp_checker u_acp_checker (.*);
